// File: rtl/rpp_pkg.sv
// Shared types and constants for the refcounted pixel plotter.
package rpp_pkg;

	localparam int IDX_W   = 12;
	localparam int COORD_W = 10;
	localparam int GEO_W   = 9;
	localparam int LIMIT_W = 13;
	localparam int ADDR_W  = 16;
	localparam int CNT_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int Q_DEPTH = 2;

	localparam logic [GEO_W-1:0]   WIDTH_RST  = 9'd256;
	localparam logic [GEO_W-1:0]   HEIGHT_RST = 9'd256;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 13'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_MISSING = 2'd1,
		OP_DRAW    = 2'd2,
		OP_ERASE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] bit_addr;
	} cmd_t;

	typedef struct packed {
		logic              changed;
		logic [ADDR_W-1:0] addr;
		logic              value;
		logic              missing;
		logic              wrapped;
	} result_t;

endpackage

// File: rtl/refcounted_pixel_plotter.sv
// Refcounted pixel plotter top level: front end, command queue, back end.
// Results are registered in the back end, which takes a new point from the
// queue only after the last one has been written back, as set by the
// read-then-write of the single-port include-flag and hit-count RAMs.
// Reset: a clearing pass zeroes both RAMs; in_ready stays low meanwhile.
module refcounted_pixel_plotter #(
	parameter int MAX_POINTS = 4096,
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpp_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rpp_pkg::IDX_W-1:0]     point_index,
	input  logic [rpp_pkg::COORD_W-1:0]   pixel_x,
	input  logic [rpp_pkg::COORD_W-1:0]   pixel_y,
	input  logic                          pixel_found,
	input  logic                          keep_going,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          bit_changed,
	output logic [rpp_pkg::ADDR_W-1:0]    bit_address,
	output logic                          bit_value,
	output logic                          point_missing,
	output logic                          count_wrapped
);

	localparam int CNT_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PA_W      = $clog2(MAX_POINTS);
	localparam int CA_W      = $clog2(CNT_DEPTH);
	localparam int CMD_W     = $bits(rpp_pkg::cmd_t);
	localparam int DATA_W    = CMD_W + PA_W + CA_W;

	rpp_pkg::cmd_t      f_cmd, q_cmd;
	logic [PA_W-1:0]    f_pt_addr, q_pt_addr;
	logic [CA_W-1:0]    f_cnt_addr, q_cnt_addr;
	logic               push, pop, q_full, q_empty, clearing;
	logic [DATA_W-1:0]  q_rdata;
	rpp_pkg::result_t   res;

	rpp_front #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PA_W       (PA_W),
		.CA_W       (CA_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_index (point_index),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_found (pixel_found),
		.keep_going  (keep_going),
		.clearing    (clearing),
		.q_full      (q_full),
		.push        (push),
		.cmd         (f_cmd),
		.pt_addr     (f_pt_addr),
		.cnt_addr    (f_cnt_addr)
	);

	rpp_queue #(.DATA_W(DATA_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_cmd, f_pt_addr, f_cnt_addr}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_cmd      = rpp_pkg::cmd_t'(q_rdata[DATA_W-1 -: CMD_W]);
	assign q_pt_addr  = q_rdata[CA_W +: PA_W];
	assign q_cnt_addr = q_rdata[CA_W-1:0];

	rpp_back #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_DEPTH  (CNT_DEPTH),
		.PA_W       (PA_W),
		.CA_W       (CA_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop        (pop),
		.q_cmd      (q_cmd),
		.q_pt_addr  (q_pt_addr),
		.q_cnt_addr (q_cnt_addr),
		.clearing   (clearing),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign bit_changed   = res.changed;
	assign bit_address   = res.addr;
	assign bit_value     = res.value;
	assign point_missing = res.missing;
	assign count_wrapped = res.wrapped;

endmodule

// File: rtl/rpp_ram.sv
// Generic single-port RAM with registered read.
module rpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rpp_queue.sv
// Short FIFO between the classify front end and the update back end.
module rpp_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (rpp_pkg::Q_DEPTH > 1) ? $clog2(rpp_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(rpp_pkg::Q_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rpp_pkg::Q_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rpp_pkg::Q_DEPTH);

	logic [DATA_W-1:0] slot_q [rpp_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/rpp_front.sv
// Front end: configuration registers, input acceptance and point classification.
module rpp_front #(
	parameter int MAX_POINTS = 4096,
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PA_W       = 12,
	parameter int CA_W       = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpp_pkg::LIMIT_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rpp_pkg::IDX_W-1:0]      point_index,
	input  logic [rpp_pkg::COORD_W-1:0]    pixel_x,
	input  logic [rpp_pkg::COORD_W-1:0]    pixel_y,
	input  logic                           pixel_found,
	input  logic                           keep_going,
	input  logic                           clearing,
	input  logic                           q_full,
	output logic                           push,
	output rpp_pkg::cmd_t                  cmd,
	output logic [PA_W-1:0]                pt_addr,
	output logic [CA_W-1:0]                cnt_addr
);

	localparam int CW = rpp_pkg::COORD_W;
	localparam int GW = rpp_pkg::GEO_W;

	logic [GW-1:0]                 width_q, height_q;
	logic [rpp_pkg::LIMIT_W-1:0]   limit_q;
	logic [GW-1:0]                 w_sat, h_sat;
	logic [CW-1:0]                 stride;
	logic [2*CW-1:0]               row_b;
	logic [CW+GW-1:0]              row_c;
	logic                          legal, in_area;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rpp_pkg::WIDTH_RST;
			height_q <= rpp_pkg::HEIGHT_RST;
			limit_q  <= rpp_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rpp_pkg::REG_WIDTH:  width_q  <= cfg_data[GW-1:0];
				rpp_pkg::REG_HEIGHT: height_q <= cfg_data[GW-1:0];
				rpp_pkg::REG_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_sat = (32'(width_q) > MAX_WIDTH) ? GW'(MAX_WIDTH) : width_q;
		h_sat = (32'(height_q) > MAX_HEIGHT) ? GW'(MAX_HEIGHT) : height_q;
		stride = (CW'(w_sat) + CW'(15)) & ~CW'(15);
		legal  = (32'(limit_q) <= MAX_POINTS) && (32'(point_index) < MAX_POINTS);
		in_area = (pixel_x < CW'(w_sat)) && (pixel_y < CW'(h_sat)) && keep_going;
		row_b  = pixel_y * stride;
		row_c  = pixel_y * w_sat;

		cmd.bit_addr = rpp_pkg::ADDR_W'(row_b + (2*CW)'(pixel_x));
		if (!legal) begin
			cmd.op = rpp_pkg::OP_NONE;
		end else if (!pixel_found) begin
			cmd.op = rpp_pkg::OP_MISSING;
		end else if (in_area) begin
			cmd.op = ({1'b0, point_index} < limit_q) ? rpp_pkg::OP_DRAW
			                                          : rpp_pkg::OP_ERASE;
		end else begin
			cmd.op = rpp_pkg::OP_NONE;
		end
		pt_addr  = PA_W'(point_index);
		cnt_addr = CA_W'(row_c + (CW+GW)'(pixel_x));
	end

	assign in_ready = !clearing && !q_full;
	assign push     = in_valid && in_ready;

endmodule

// File: rtl/rpp_back.sv
// Back end: read-modify-write of include flags and hit counts, result register.
module rpp_back #(
	parameter int MAX_POINTS = 4096,
	parameter int CNT_DEPTH  = 65536,
	parameter int PA_W       = 12,
	parameter int CA_W       = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              pop,
	input  rpp_pkg::cmd_t     q_cmd,
	input  logic [PA_W-1:0]   q_pt_addr,
	input  logic [CA_W-1:0]   q_cnt_addr,
	output logic              clearing,
	output logic              res_valid,
	input  logic              res_ready,
	output rpp_pkg::result_t  res
);

	localparam int CLR_N = (MAX_POINTS > CNT_DEPTH) ? MAX_POINTS : CNT_DEPTH;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

	state_t                     state_q;
	logic [CLR_W-1:0]           clr_q;
	rpp_pkg::cmd_t              cmd_q;
	logic [PA_W-1:0]            pt_addr_q;
	logic [CA_W-1:0]            cnt_addr_q;
	rpp_pkg::result_t           res_q;
	logic                       res_valid_q;

	logic                       pt_we, pt_re, cnt_we, cnt_re;
	logic [PA_W-1:0]            pt_addr;
	logic [CA_W-1:0]            cnt_addr;
	logic                       pt_wdata, pt_rdata;
	logic [rpp_pkg::CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_inc, cnt_dec;
	logic                       slot_free, exec_go;
	rpp_pkg::result_t           res_next;

	rpp_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_incl_ram (
		.clk   (clk),
		.we    (pt_we),
		.re    (pt_re),
		.addr  (pt_addr),
		.wdata (pt_wdata),
		.rdata (pt_rdata)
	);

	rpp_ram #(.WIDTH(rpp_pkg::CNT_W), .DEPTH(CNT_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.re    (cnt_re),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	assign clearing  = (state_q == ST_CLEAR);
	assign slot_free = !res_valid_q || res_ready;
	assign exec_go   = (state_q == ST_EXEC) && slot_free;
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign cnt_inc   = cnt_rdata + 1'b1;
	assign cnt_dec   = cnt_rdata - 1'b1;

	always_comb begin
		pt_we     = 1'b0;
		pt_re     = 1'b0;
		cnt_we    = 1'b0;
		cnt_re    = 1'b0;
		pt_addr   = pt_addr_q;
		cnt_addr  = cnt_addr_q;
		pt_wdata  = 1'b0;
		cnt_wdata = '0;
		res_next  = '0;
		case (state_q)
			ST_CLEAR: begin
				pt_addr  = clr_q[PA_W-1:0];
				cnt_addr = clr_q[CA_W-1:0];
				pt_we    = (32'(clr_q) < MAX_POINTS);
				cnt_we   = (32'(clr_q) < CNT_DEPTH);
			end
			ST_IDLE: begin
				pt_addr  = q_pt_addr;
				cnt_addr = q_cnt_addr;
				pt_re    = pop && (q_cmd.op == rpp_pkg::OP_DRAW ||
				                   q_cmd.op == rpp_pkg::OP_ERASE);
				cnt_re   = pt_re;
			end
			ST_EXEC: begin
				case (cmd_q.op)
					rpp_pkg::OP_MISSING: res_next.missing = 1'b1;
					rpp_pkg::OP_DRAW: begin
						if (!pt_rdata) begin
							pt_we            = exec_go;
							cnt_we           = exec_go;
							pt_wdata         = 1'b1;
							cnt_wdata        = cnt_inc;
							res_next.wrapped = (cnt_inc == '0);
							res_next.changed = (cnt_inc == rpp_pkg::CNT_W'(1));
						end
					end
					rpp_pkg::OP_ERASE: begin
						if (pt_rdata) begin
							pt_we            = exec_go;
							cnt_we           = exec_go;
							pt_wdata         = 1'b0;
							cnt_wdata        = cnt_dec;
							res_next.wrapped = (cnt_dec == '1);
							res_next.changed = (cnt_dec == '0);
							res_next.value   = res_next.changed;
						end
					end
					default: ;
				endcase
				res_next.addr = res_next.changed ? cmd_q.bit_addr : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cmd_q       <= '0;
			pt_addr_q   <= '0;
			cnt_addr_q  <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= exec_go || (res_valid_q && !res_ready);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cmd_q      <= q_cmd;
						pt_addr_q  <= q_pt_addr;
						cnt_addr_q <= q_cnt_addr;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						res_q   <= res_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
